>>> rtl/sal_pkg.sv
`default_nettype none

package sal_pkg;

  localparam int unsigned ADDR_W         = 64;
  localparam int unsigned SIZE_W         = 40;
  localparam int unsigned ALIGN_LOG2_W   = 5;
  // widest alignment mask: 2^31 - 1
  localparam int unsigned AMASK_W        = 31;
  localparam int unsigned PAGE_SIZE_DEF  = 4096;
  localparam logic [ADDR_W-1:0] BASE_ADDR_RST = 64'h0000_0000_0040_0000;

  // kind of the previously laid out section
  typedef enum logic [1:0] {
    KIND_START,
    KIND_ALLOC,
    KIND_BSS,
    KIND_NONALLOC
  } kind_t;

  // section held in the input register, alignment already decoded
  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [AMASK_W-1:0] amask;
    logic               alloc;
    logic               bss;
    logic               tls;
    logic               page_start;
    logic               last;
  } sal_item_t;

endpackage

`default_nettype wire

>>> rtl/sal_in_if.sv
`default_nettype none

interface sal_in_if;
  logic        valid;
  logic        ready;
  logic [39:0] section_size;
  logic [4:0]  align_log2;
  logic        is_alloc;
  logic        is_bss;
  logic        is_tls;
  logic        start_new_page;
  logic        last_section;

  modport source (
    output valid, section_size, align_log2, is_alloc, is_bss, is_tls,
           start_new_page, last_section,
    input  ready
  );

  modport sink (
    input  valid, section_size, align_log2, is_alloc, is_bss, is_tls,
           start_new_page, last_section,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sal_out_if.sv
`default_nettype none

interface sal_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] section_addr;
  logic [63:0] file_offset;
  logic [63:0] file_end;
  logic        order_error;

  modport source (
    output valid, section_addr, file_offset, file_end, order_error,
    input  ready
  );

  modport sink (
    input  valid, section_addr, file_offset, file_end, order_error,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sal_in_stage.sv
`default_nettype none

module sal_in_stage
  import sal_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  sal_in_if.sink     in_sec,
  input  wire logic  take,
  output sal_item_t  item,
  output logic       item_valid
);

  logic      valid_r;
  sal_item_t item_r;
  sal_item_t item_nxt;

  // register is free when empty or when its section moves on this cycle
  assign in_sec.ready = !valid_r || take;

  // decode the alignment into a low-bit mask on the way in
  always_comb begin
    item_nxt.size       = in_sec.section_size;
    item_nxt.amask      = AMASK_W'((32'd1 << in_sec.align_log2) - 32'd1);
    item_nxt.alloc      = in_sec.is_alloc;
    item_nxt.bss        = in_sec.is_bss;
    item_nxt.tls        = in_sec.is_tls;
    item_nxt.page_start = in_sec.start_new_page;
    item_nxt.last       = in_sec.last_section;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_sec.valid && in_sec.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_sec.valid && in_sec.ready) begin
      item_r <= item_nxt;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

>>> rtl/sal_layout_core.sv
`default_nettype none

module sal_layout_core
  import sal_pkg::*;
#(
  parameter int unsigned PAGE_SIZE = PAGE_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire sal_item_t         item,
  input  wire logic              item_valid,
  output logic                   take,
  sal_out_if.source              out_res
);

  localparam int unsigned PW = $clog2(PAGE_SIZE);
  localparam logic [AMASK_W-1:0] PAGE_MASK = AMASK_W'(PAGE_SIZE - 1);

  logic [ADDR_W-1:0] base_addr_r;
  logic [ADDR_W-1:0] vaddr_r, vaddr_nxt;
  logic [ADDR_W-1:0] foff_r, foff_nxt;
  kind_t             kind_r, kind_nxt;

  logic              out_valid_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic              err_r, err_nxt;

  logic              alloc_eff;
  logic              open_grp;
  logic [AMASK_W-1:0] vmask;
  logic [ADDR_W-1:0] delta;
  logic [ADDR_W-1:0] v;
  logic [PW-1:0]     k1, f1_low, k2;
  logic [PW:0]       k12;
  logic [AMASK_W-1:0] fpad;
  logic [ADDR_W-1:0] size_ext;

  // a section moves into the result register when it is empty or drained
  assign take = item_valid && (!out_valid_r || out_res.ready);

  always_comb begin
    size_ext  = {{(ADDR_W-SIZE_W){1'b0}}, item.size};
    err_nxt   = item.alloc && (kind_r == KIND_NONALLOC);
    alloc_eff = item.alloc && (kind_r != KIND_NONALLOC);
    open_grp  = (kind_r == KIND_START) || ((kind_r == KIND_BSS) && !item.bss);

    // page and section alignment merge into one mask (both powers of two)
    vmask = item.amask | (item.page_start ? PAGE_MASK : '0);
    delta = {{(ADDR_W-AMASK_W){1'b0}},
             (~vaddr_r[AMASK_W-1:0] + AMASK_W'(1)) & vmask};
    v     = vaddr_r + delta;

    // page skew of the file offset, done on the low bits only
    k1     = open_grp ? (vaddr_r[PW-1:0] - foff_r[PW-1:0]) : '0;
    f1_low = foff_r[PW-1:0] + k1;
    k2     = v[PW-1:0] - f1_low;
    k12    = {1'b0, k1} + {1'b0, k2};

    // padding for a non-allocated section
    fpad = (~foff_r[AMASK_W-1:0] + AMASK_W'(1)) & item.amask;

    vaddr_nxt = vaddr_r;
    kind_nxt  = KIND_NONALLOC;
    addr_nxt  = '0;
    if (alloc_eff && !item.bss) begin
      off_nxt   = foff_r + {{(ADDR_W-PW){1'b0}}, k1} + delta;
      foff_nxt  = off_nxt + size_ext;
      vaddr_nxt = v + size_ext;
      addr_nxt  = v;
      kind_nxt  = KIND_ALLOC;
    end else if (alloc_eff) begin
      off_nxt   = foff_r + {{(ADDR_W-PW-1){1'b0}}, k12};
      foff_nxt  = off_nxt;
      vaddr_nxt = item.tls ? v : v + size_ext;
      addr_nxt  = v;
      kind_nxt  = KIND_BSS;
    end else begin
      off_nxt  = foff_r + {{(ADDR_W-AMASK_W){1'b0}}, fpad};
      foff_nxt = off_nxt + size_ext;
    end

    end_nxt = item.last ? foff_nxt : '0;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_addr_r <= BASE_ADDR_RST;
    end else if (cfg_we) begin
      base_addr_r <= cfg_wdata;
    end
  end

  // running layout state, back to start after the last section
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vaddr_r <= BASE_ADDR_RST;
      foff_r  <= '0;
      kind_r  <= KIND_START;
    end else if (take) begin
      if (item.last) begin
        vaddr_r <= base_addr_r;
        foff_r  <= '0;
        kind_r  <= KIND_START;
      end else begin
        vaddr_r <= vaddr_nxt;
        foff_r  <= foff_nxt;
        kind_r  <= kind_nxt;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      addr_r <= addr_nxt;
      off_r  <= off_nxt;
      end_r  <= end_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.section_addr = addr_r;
  assign out_res.file_offset  = off_r;
  assign out_res.file_end     = end_r;
  assign out_res.order_error  = err_r;

endmodule

`default_nettype wire

>>> rtl/section_address_layout.sv
`default_nettype none

// Section address and file offset layout. Sorted output sections arrive one
// per transfer on in_sec; each yields one transfer on out_res with its virtual
// address, file offset, the file size when it is the last section, and an
// order error flag. A section can be accepted every clock while out_res.ready
// is high; its result passes through the input register and then the result
// register before it is presented on out_res. The running address and offset
// advance in the cycle in which a section moves from the input register to the
// result register; a result held by a deasserted out_res.ready keeps the next
// section in the input register and so stalls in_sec. A write to the base
// address takes effect after the next last section, and reset restores the
// default base; the running state returns to start after every last section.
module section_address_layout
  import sal_pkg::*;
#(
  parameter int unsigned PAGE_SIZE = PAGE_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  sal_in_if.sink                 in_sec,
  sal_out_if.source              out_res
);

  sal_item_t item;
  logic      item_valid;
  logic      take;

  // input register with alignment decode
  sal_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_sec     (in_sec),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  // running layout state and result register
  sal_layout_core #(
    .PAGE_SIZE (PAGE_SIZE)
  ) u_layout_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .item_valid (item_valid),
    .take       (take),
    .out_res    (out_res)
  );

endmodule

`default_nettype wire

>>> tb/tb_section_address_layout.sv
`default_nettype none

module tb_section_address_layout;
  import sal_pkg::*;

  localparam int unsigned PAGE    = PAGE_SIZE_DEF;
  // section register plus result register
  localparam int unsigned LATENCY = 2;

  // one section as driven on the input channel
  typedef struct {
    logic [SIZE_W-1:0]       size;
    logic [ALIGN_LOG2_W-1:0] align_log2;
    logic                    alloc;
    logic                    bss;
    logic                    tls;
    logic                    page_start;
    logic                    last;
  } section_t;

  // placement of one section as returned on the result channel
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] file_end;
    logic              order_error;
  } placement_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  sal_in_if  sec_if ();
  sal_out_if res_if ();

  section_address_layout #(
    .PAGE_SIZE (PAGE)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_sec    (sec_if),
    .out_res   (res_if)
  );

  // layout state as the block should hold it
  logic [ADDR_W-1:0] base_reg;
  logic [ADDR_W-1:0] cur_vaddr;
  logic [ADDR_W-1:0] cur_fileoff;
  kind_t             last_kind;

  section_t   pending_sections[$];
  placement_t expected_placements[$];
  int         mismatches;
  int         queued;
  int         send_idle_pct;
  int         recv_idle_pct;
  logic       sec_taken;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [ADDR_W-1:0] align_up(logic [ADDR_W-1:0] v,
                                                 logic [ADDR_W-1:0] mask);
    return (v + mask) & ~mask;
  endfunction

  // smallest offset at or above v that is congruent to addr modulo the page
  function automatic logic [ADDR_W-1:0] page_skew(logic [ADDR_W-1:0] v,
                                                  logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] s;
    s = addr & (PAGE - 1);
    return align_up(v + PAGE - s, PAGE - 1) - PAGE + s;
  endfunction

  // lay out one section and advance the running address and offset
  function automatic placement_t place_section(section_t s);
    placement_t        r;
    logic [ADDR_W-1:0] v;
    logic [ADDR_W-1:0] amask;
    logic              alloc;
    amask = (64'd1 << s.align_log2) - 64'd1;
    r = '{default: '0};
    alloc = s.alloc;
    // allocated after non-allocated falls back to non-allocated layout
    if (alloc && last_kind == KIND_NONALLOC) begin
      r.order_error = 1'b1;
      alloc = 1'b0;
    end
    if (alloc) begin
      v = cur_vaddr;
      // a new group makes the offset congruent to the address first
      if (last_kind == KIND_START || (last_kind == KIND_BSS && !s.bss)) begin
        cur_fileoff = page_skew(cur_fileoff, v);
      end
      if (s.page_start) begin
        v = align_up(v, PAGE - 1);
      end
      v = align_up(v, amask);
      if (!s.bss) begin
        cur_fileoff = cur_fileoff + (v - cur_vaddr);
        r.addr = v;
        r.offset = cur_fileoff;
        cur_vaddr = v + s.size;
        cur_fileoff = cur_fileoff + s.size;
        last_kind = KIND_ALLOC;
      end else begin
        cur_fileoff = page_skew(cur_fileoff, v);
        r.addr = v;
        r.offset = cur_fileoff;
        cur_vaddr = s.tls ? v : v + s.size;
        last_kind = KIND_BSS;
      end
    end else begin
      cur_fileoff = align_up(cur_fileoff, amask);
      r.offset = cur_fileoff;
      cur_fileoff = cur_fileoff + s.size;
      last_kind = KIND_NONALLOC;
    end
    // end of layout: report file size and restart from the base
    if (s.last) begin
      r.file_end = cur_fileoff;
      cur_vaddr = base_reg;
      cur_fileoff = '0;
      last_kind = KIND_START;
    end
    return r;
  endfunction

  // predict on each section transfer, check each result transfer
  always @(posedge clk) begin : check_results
    placement_t want;
    section_t   got_sec;
    if (!rst_n) begin
      base_reg = BASE_ADDR_RST;
      cur_vaddr = BASE_ADDR_RST;
      cur_fileoff = '0;
      last_kind = KIND_START;
      sec_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_reg = cfg_wdata;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_placements.size() == 0) begin
          $display("%0t: result transfer with none expected, got addr %h offset %h",
                   $time, res_if.section_addr, res_if.file_offset);
          mismatches++;
        end else begin
          want = expected_placements.pop_front();
          if (res_if.section_addr !== want.addr) begin
            $display("%0t: section_addr expected %h, got %h",
                     $time, want.addr, res_if.section_addr);
            mismatches++;
          end
          if (res_if.file_offset !== want.offset) begin
            $display("%0t: file_offset expected %h, got %h",
                     $time, want.offset, res_if.file_offset);
            mismatches++;
          end
          if (res_if.file_end !== want.file_end) begin
            $display("%0t: file_end expected %h, got %h",
                     $time, want.file_end, res_if.file_end);
            mismatches++;
          end
          if (res_if.order_error !== want.order_error) begin
            $display("%0t: order_error expected %b, got %b",
                     $time, want.order_error, res_if.order_error);
            mismatches++;
          end
        end
      end
      if (sec_if.valid && sec_if.ready) begin
        got_sec.size       = sec_if.section_size;
        got_sec.align_log2 = sec_if.align_log2;
        got_sec.alloc      = sec_if.is_alloc;
        got_sec.bss        = sec_if.is_bss;
        got_sec.tls        = sec_if.is_tls;
        got_sec.page_start = sec_if.start_new_page;
        got_sec.last       = sec_if.last_section;
        want = place_section(got_sec);
        expected_placements.insert(expected_placements.size(), want);
      end
      sec_taken <= sec_if.valid && sec_if.ready;
    end
  end

  // section driver
  always @(negedge clk) begin : drive_sections
    section_t nxt;
    if (!rst_n) begin
      sec_if.valid <= 1'b0;
    end else if (!sec_if.valid || sec_taken) begin
      if (pending_sections.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_sections.pop_front();
        sec_if.section_size   <= nxt.size;
        sec_if.align_log2     <= nxt.align_log2;
        sec_if.is_alloc       <= nxt.alloc;
        sec_if.is_bss         <= nxt.bss;
        sec_if.is_tls         <= nxt.tls;
        sec_if.start_new_page <= nxt.page_start;
        sec_if.last_section   <= nxt.last;
        sec_if.valid          <= 1'b1;
      end else begin
        sec_if.valid <= 1'b0;
      end
    end
  end

  // result back pressure
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic section_t mk_section(logic [SIZE_W-1:0] size,
                                          logic [ALIGN_LOG2_W-1:0] al,
                                          logic alloc, logic bss, logic tls,
                                          logic np, logic last);
    section_t s;
    s.size = size;
    s.align_log2 = al;
    s.alloc = alloc;
    s.bss = bss;
    s.tls = tls;
    s.page_start = np;
    s.last = last;
    return s;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return SIZE_W'({$urandom, $urandom});
    if (pick == 2) return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(12000));
  endfunction

  function automatic section_t rand_section(logic alloc, logic bss);
    logic [ALIGN_LOG2_W-1:0] al;
    al = ($urandom_range(3) == 0) ? ALIGN_LOG2_W'($urandom_range(31))
                                  : ALIGN_LOG2_W'($urandom_range(12));
    return mk_section(rand_size(), al, alloc, bss, $urandom_range(3) == 0,
                      $urandom_range(3) == 0, 1'b0);
  endfunction

  task automatic push_section(section_t s);
    pending_sections.insert(pending_sections.size(), s);
    queued++;
  endtask

  // well-formed layout: allocated sections, then non-allocated, the final one marked last
  task automatic push_layout();
    int n_alloc;
    int n_non;
    section_t s;
    n_alloc = $urandom_range(6);
    n_non = $urandom_range(3);
    if (n_alloc + n_non == 0) n_alloc = 1;
    for (int i = 0; i < n_alloc + n_non; i++) begin
      if (i < n_alloc) s = rand_section(1'b1, $urandom_range(2) == 0);
      else s = rand_section(1'b0, $urandom_range(3) == 0);
      s.last = (i == n_alloc + n_non - 1);
      push_section(s);
    end
  endtask

  // unordered sections with every flag random
  task automatic push_noise();
    section_t s;
    repeat ($urandom_range(1, 3)) begin
      s = rand_section(1'($urandom_range(1)), 1'($urandom_range(1)));
      s.last = ($urandom_range(4) == 0);
      push_section(s);
    end
  endtask

  // hold off until every section has been placed and checked
  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending_sections.size() == 0 && !sec_if.valid &&
             expected_placements.size() == 0));
  endtask

  task automatic write_base(logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus sequence
  initial begin : run_layouts
    int start_count;
    logic [ADDR_W-1:0] bases [6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sec_if.valid = 1'b0;
    sec_if.section_size = '0;
    sec_if.align_log2 = '0;
    sec_if.is_alloc = 1'b0;
    sec_if.is_bss = 1'b0;
    sec_if.is_tls = 1'b0;
    sec_if.start_new_page = 1'b0;
    sec_if.last_section = 1'b0;
    res_if.ready = 1'b0;
    mismatches = 0;
    queued = 0;
    send_idle_pct = 31;
    recv_idle_pct = 65;
    bases[0] = BASE_ADDR_RST;
    bases[1] = '0;
    bases[2] = '1;
    bases[3] = 64'hFFFF_FFFF_FFFF_F123;
    bases[4] = 64'h0000_0000_0040_1234;
    bases[5] = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 65 : 0;
      recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 31 : 0;
      if (ph > 0) begin
        wait_drained();
        repeat (LATENCY + 2) @(negedge clk);
        write_base(bases[ph]);
      end
      if (ph == 0) begin
        // first section opens a group, zero size, byte aligned
        push_section(mk_section('0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        // page start with the largest size
        push_section(mk_section('1, 5'd12, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        // widest alignment
        push_section(mk_section(40'h10, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        // bss, then thread-local bss that does not grow the address
        push_section(mk_section(40'h100, 5'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        push_section(mk_section(40'h1000, 5'd4, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        // file contents after bss reopen a group, tls ignored
        push_section(mk_section(40'h333, 5'd5, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        // non-allocated, plain and with the bss flag
        push_section(mk_section(40'h5, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        push_section(mk_section(40'h77, 5'd4, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        // allocated after non-allocated is an order error
        push_section(mk_section(40'h40, 5'd6, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        push_section(mk_section('1, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // bss as the very first section, also the last
        push_section(mk_section(40'h2000, 5'd12, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        // lone non-allocated layout
        push_section(mk_section(40'h9, 5'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // lone allocated layout with every flag but bss set
        push_section(mk_section(40'hAA, 5'd31, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        wait_drained();
      end
      start_count = queued;
      while (queued - start_count < 58) begin
        if ($urandom_range(9) < 8) push_layout();
        else push_noise();
      end
      // sender pauses until all results are back
      wait_drained();
      while (queued - start_count < 117) begin
        if ($urandom_range(9) < 8) push_layout();
        else push_noise();
      end
    end

    wait_drained();
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0 && expected_placements.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/sal_pkg.sv
rtl/sal_in_if.sv
rtl/sal_out_if.sv
rtl/sal_in_stage.sv
rtl/sal_layout_core.sv
rtl/section_address_layout.sv
tb/tb_section_address_layout.sv
